[sv/nvram_text_packer_defines.svh]
// Assertion macros used by nvram_text_packer, the file that checks its own logic.
// Each macro expands to nothing when SYNTHESIS is defined.
`ifndef NVRAM_TEXT_PACKER_DEFINES_SVH
`define NVRAM_TEXT_PACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define NVTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NVTP_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define NVTP_ASSERT(lbl, prop, msg)
`define NVTP_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

[sv/nvtp_pkg.sv]
package nvtp_pkg;

  localparam int COUNT_WIDTH_DEF = 18;
  localparam int POS_WIDTH       = 18;
  localparam int TOKEN_HALF      = 16;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  localparam logic [1:0] TOKEN_LAST_STEP = 2'd3;

  typedef enum logic [0:0] {
    ACT_TEXT   = 1'b0,
    ACT_FINISH = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    TAIL_IDLE,
    TAIL_EXTRA,
    TAIL_PAD,
    TAIL_TOKEN
  } tail_state_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [POS_WIDTH-1:0] position;
    logic                 last;
  } out_item_t;

  // Line state that the text filter looks at.
  typedef struct packed {
    logic comment;
    logic at_line_start;
    logic last_was_nul;
    logic count_nz;
  } text_state_t;

  typedef struct packed {
    logic       emit;
    logic       comment;
    logic       at_line_start;
    logic [7:0] out_byte;
  } filt_t;

  typedef struct packed {
    logic       busy;
    logic       emit;
    logic       last;
    logic       done;
    logic [7:0] out_byte;
  } tail_t;

endpackage

[sv/nvtp_text_filter.sv]
module nvtp_text_filter (
  input  nvtp_pkg::text_state_t state_i,
  input  logic [7:0]            text_byte_i,
  output nvtp_pkg::filt_t       filt_o
);
  import nvtp_pkg::*;

  always_comb begin
    filt_o.emit          = 1'b0;
    filt_o.comment       = state_i.comment;
    filt_o.at_line_start = state_i.at_line_start;
    filt_o.out_byte      = text_byte_i;
    if (text_byte_i == CHAR_CR) begin
      filt_o.emit = 1'b0;
    end else if (text_byte_i == CHAR_LF) begin
      // A newline closes a line with content by one NUL, never two in a row.
      filt_o.emit          = !state_i.comment && !state_i.at_line_start &&
                             state_i.count_nz && !state_i.last_was_nul;
      filt_o.out_byte      = CHAR_NUL;
      filt_o.comment       = 1'b0;
      filt_o.at_line_start = 1'b1;
    end else if (state_i.at_line_start && (text_byte_i == CHAR_HASH)) begin
      filt_o.comment       = 1'b1;
      filt_o.at_line_start = 1'b0;
    end else begin
      filt_o.at_line_start = 1'b0;
      filt_o.emit          = !state_i.comment;
    end
  end

endmodule

[sv/nvtp_finish_seq.sv]
module nvtp_finish_seq #(
  parameter int COUNT_WIDTH = nvtp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   need_term_i,
  input  logic                   emit_ok_i,
  input  logic [COUNT_WIDTH-1:0] count_inc_i,
  output nvtp_pkg::tail_t        tail_o
);
  import nvtp_pkg::*;

  tail_state_e             state_q, state_d;
  logic [1:0]              step_q, step_d;
  logic [TOKEN_HALF-1:0]   nwords_q, nwords_d;

  logic [COUNT_WIDTH+TOKEN_HALF-1:0] cnt_ext;
  logic [TOKEN_HALF-1:0]             nwords_new;
  logic [1:0]                        pads;
  logic [2*TOKEN_HALF-1:0]           token;

  // Word count and padding are taken from the count after the byte sent now.
  assign cnt_ext    = {{TOKEN_HALF{1'b0}}, count_inc_i};
  assign nwords_new = cnt_ext[TOKEN_HALF+1:2];
  assign pads       = 2'b00 - count_inc_i[1:0];
  assign token      = {~nwords_q, nwords_q};

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    nwords_d = nwords_q;
    unique case (state_q)
      TAIL_IDLE: begin
        if (start_i) begin
          if (need_term_i) begin
            state_d = TAIL_EXTRA;
          end else if (pads == 2'd0) begin
            state_d  = TAIL_TOKEN;
            step_d   = 2'd0;
            nwords_d = nwords_new;
          end else begin
            state_d = TAIL_PAD;
            step_d  = pads;
          end
        end
      end
      TAIL_EXTRA: begin
        if (emit_ok_i) begin
          if (pads == 2'd0) begin
            state_d  = TAIL_TOKEN;
            step_d   = 2'd0;
            nwords_d = nwords_new;
          end else begin
            state_d = TAIL_PAD;
            step_d  = pads;
          end
        end
      end
      TAIL_PAD: begin
        if (emit_ok_i) begin
          if (step_q == 2'd1) begin
            state_d  = TAIL_TOKEN;
            step_d   = 2'd0;
            nwords_d = nwords_new;
          end else begin
            step_d = step_q - 2'd1;
          end
        end
      end
      TAIL_TOKEN: begin
        if (emit_ok_i) begin
          step_d = step_q + 2'd1;
          if (step_q == TOKEN_LAST_STEP) begin
            state_d = TAIL_IDLE;
          end
        end
      end
      default: state_d = TAIL_IDLE;
    endcase
  end

  always_comb begin
    tail_o.busy     = (state_q != TAIL_IDLE);
    tail_o.emit     = (state_q != TAIL_IDLE) && emit_ok_i;
    tail_o.last     = (state_q == TAIL_TOKEN) && (step_q == TOKEN_LAST_STEP);
    tail_o.done     = tail_o.last && emit_ok_i;
    tail_o.out_byte = CHAR_NUL;
    if (state_q == TAIL_TOKEN) begin
      tail_o.out_byte = token[{step_q, 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TAIL_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nwords_q <= nwords_d;
  end

endmodule

[sv/nvram_text_packer.sv]
// Text bytes: one transaction per cycle while in_stall_o is low, the packed byte (if any) appears in the cycle after.
// Throughput is set by the single output register: one packed byte per cycle at most.
// Finish: the first NUL leaves in the cycle after acceptance, then up to eight more bytes
// follow one per cycle, while the output is not stalled, from the tail sequencer while the input is stalled.
// Asynchronous active-low reset clears the line state, the byte count and the output valid.
`include "nvram_text_packer_defines.svh"

module nvram_text_packer #(
  parameter int COUNT_WIDTH = nvtp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nvtp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nvtp_pkg::out_item_t out_item_o
);
  import nvtp_pkg::*;

  logic                   comment_q, comment_d;
  logic                   at_line_start_q, at_line_start_d;
  logic                   last_was_nul_q, last_was_nul_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d, count_inc;
  logic                   out_valid_q;
  out_item_t              out_item_q;

  logic        emit_ok, accept_in, is_finish, start;
  logic        em, em_last;
  logic [7:0]  em_byte;
  text_state_t text_state;
  filt_t       filt;
  tail_t       tail;

  logic [COUNT_WIDTH+POS_WIDTH-1:0] pos_ext;

  assign emit_ok    = !out_valid_q || !out_stall_i;
  assign in_stall_o = tail.busy || !emit_ok;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign is_finish  = (in_item_i.action == ACT_FINISH);
  assign start      = accept_in && is_finish;

  assign count_inc = (count_q == {COUNT_WIDTH{1'b1}}) ? count_q : count_q + 1'b1;
  assign pos_ext   = {{POS_WIDTH{1'b0}}, count_q};

  assign text_state = '{
    comment:       comment_q,
    at_line_start: at_line_start_q,
    last_was_nul:  last_was_nul_q,
    count_nz:      (count_q != '0)
  };

  nvtp_text_filter u_filter (
    .state_i     (text_state),
    .text_byte_i (in_item_i.text_byte),
    .filt_o      (filt)
  );

  nvtp_finish_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .need_term_i ((count_q != '0) && !last_was_nul_q),
    .emit_ok_i   (emit_ok),
    .count_inc_i (count_inc),
    .tail_o      (tail)
  );

  // Pick the byte sent this cycle: tail sequencer, finish opener, or filtered text.
  always_comb begin
    em      = 1'b0;
    em_byte = CHAR_NUL;
    em_last = 1'b0;
    if (tail.busy) begin
      em      = tail.emit;
      em_byte = tail.out_byte;
      em_last = tail.last;
    end else if (start) begin
      em = 1'b1;
    end else if (accept_in) begin
      em      = filt.emit;
      em_byte = filt.out_byte;
    end
  end

  always_comb begin
    comment_d       = comment_q;
    at_line_start_d = at_line_start_q;
    last_was_nul_d  = last_was_nul_q;
    count_d         = count_q;
    if (em) begin
      count_d        = count_inc;
      last_was_nul_d = (em_byte == CHAR_NUL);
    end
    if (accept_in && !is_finish) begin
      comment_d       = filt.comment;
      at_line_start_d = filt.at_line_start;
    end
    if (tail.done) begin
      comment_d       = 1'b0;
      at_line_start_d = 1'b1;
      last_was_nul_d  = 1'b0;
      count_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q       <= 1'b0;
      at_line_start_q <= 1'b1;
      last_was_nul_q  <= 1'b0;
      count_q         <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      comment_q       <= comment_d;
      at_line_start_q <= at_line_start_d;
      last_was_nul_q  <= last_was_nul_d;
      count_q         <= count_d;
      if (em) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (em) begin
      out_item_q.out_byte <= em_byte;
      out_item_q.position <= pos_ext[POS_WIDTH-1:0];
      out_item_q.last     <= em_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `NVTP_ASSERT(a_last_clears_count, (em && em_last) |=> (count_q == '0), "count not cleared")
  `NVTP_ASSERT(a_last_word_aligned, (em && em_last) |-> (count_q[1:0] == 2'b11), "token misaligned")
  `NVTP_ASSERT(a_finish_starts_tail, start |=> tail.busy, "finish did not start the tail")
  `NVTP_ASSERT_NORST(a_reset_no_valid, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule
